>>> hdl/cef_pkg.sv
// ----------------------------------------------------------------------------
// cef_pkg
// Types and constants shared by the ESC feedback and command block.
// ----------------------------------------------------------------------------
package cef_pkg;

  localparam int unsigned NumSlots   = 4;
  localparam int unsigned CanIdW     = 11;
  localparam int unsigned RxIdW      = 29;
  localparam int unsigned PwmW       = 16;
  localparam int unsigned CurW       = 16;

  localparam logic [3:0]          FRAME_LEN   = 4'd8;
  localparam logic [PwmW-1:0]     PWM_MIN     = 16'd1000;
  localparam logic [PwmW-1:0]     PWM_MAX     = 16'd2000;
  localparam logic signed [15:0]  PWM_MID     = 16'sd1500;
  localparam logic signed [15:0]  PWM_GAIN    = 16'sd6;
  localparam logic [15:0]         TEMP_SCALE  = 16'd100;

  localparam logic [CanIdW-1:0] FEEDBACK_ID_RESET [NumSlots] =
      '{11'd513, 11'd514, 11'd515, 11'd516};
  localparam logic [CanIdW-1:0] COMMAND_ID_RESET = 11'd512;

  typedef enum logic {
    REQ_RX_FRAME = 1'b0,
    REQ_COMMAND  = 1'b1
  } req_type_e;

  typedef enum logic {
    KIND_TELEMETRY = 1'b0,
    KIND_COMMAND   = 1'b1
  } result_kind_e;

  typedef enum logic [2:0] {
    CFG_FEEDBACK_ID_0 = 3'd0,
    CFG_FEEDBACK_ID_1 = 3'd1,
    CFG_FEEDBACK_ID_2 = 3'd2,
    CFG_FEEDBACK_ID_3 = 3'd3,
    CFG_COMMAND_ID    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic              req_type;
    logic [RxIdW-1:0]  rx_id;
    logic              rx_extended;
    logic [3:0]        rx_length;
    logic [63:0]       rx_payload;
    logic [PwmW-1:0]   pwm_slot0;
    logic [PwmW-1:0]   pwm_slot1;
    logic [PwmW-1:0]   pwm_slot2;
    logic [PwmW-1:0]   pwm_slot3;
  } in_item_t;

  typedef struct packed {
    logic                    result_kind;
    logic [1:0]              slot_index;
    logic [15:0]             speed_abs;
    logic signed [CurW-1:0]  current_centiamps;
    logic signed [15:0]      temp_centideg;
    logic [NumSlots-1:0]     detected_slots;
    logic [CanIdW-1:0]       tx_id;
    logic [3:0]              tx_length;
    logic [63:0]             tx_payload;
  } out_item_t;

  typedef struct packed {
    logic [NumSlots-1:0][CanIdW-1:0] feedback_id;
    logic [CanIdW-1:0]               command_id;
  } cfg_t;

endpackage

>>> hdl/cef_in_if.sv
// ----------------------------------------------------------------------------
// cef_in_if
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface cef_in_if;
  logic               valid;
  logic               ready;
  cef_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/cef_out_if.sv
// ----------------------------------------------------------------------------
// cef_out_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface cef_out_if;
  logic               valid;
  logic               ready;
  cef_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/cef_item_proc.sv
// ----------------------------------------------------------------------------
// cef_item_proc
// Decodes one feedback frame or builds one current command frame.
// ----------------------------------------------------------------------------
module cef_item_proc (
  input  cef_pkg::in_item_t            item_i,
  input  cef_pkg::cfg_t                cfg_i,
  input  logic [cef_pkg::NumSlots-1:0] mask_i,
  output logic                         drop_o,
  output logic [cef_pkg::NumSlots-1:0] mask_o,
  output cef_pkg::out_item_t           result_o
);
  import cef_pkg::*;

  logic [NumSlots-1:0] match;
  logic                found;
  logic [1:0]          slot;
  logic [15:0]         rpm;
  logic [15:0]         temp_raw;
  logic [15:0]         pwm     [NumSlots];
  logic [PwmW-1:0]     pwm_c   [NumSlots];
  logic signed [15:0]  offs    [NumSlots];
  logic signed [15:0]  cur     [NumSlots];
  logic [63:0]         payload;

  // lowest matching slot wins; a wide id never matches
  always_comb begin
    for (int k = 0; k < NumSlots; k++) begin
      match[k] = (item_i.rx_id == {{(RxIdW-CanIdW){1'b0}}, cfg_i.feedback_id[k]});
    end
    found = |match;
    slot  = 2'd0;
    for (int k = NumSlots-1; k >= 0; k--) begin
      if (match[k]) begin
        slot = 2'(k);
      end
    end
  end

  assign rpm      = {item_i.rx_payload[23:16], item_i.rx_payload[31:24]};
  assign temp_raw = {item_i.rx_payload[55:48], item_i.rx_payload[63:56]};

  assign pwm[0] = item_i.pwm_slot0;
  assign pwm[1] = item_i.pwm_slot1;
  assign pwm[2] = item_i.pwm_slot2;
  assign pwm[3] = item_i.pwm_slot3;

  always_comb begin
    payload = '0;
    for (int k = 0; k < NumSlots; k++) begin
      if (pwm[k] < PWM_MIN) begin
        pwm_c[k] = PWM_MIN;
      end else if (pwm[k] > PWM_MAX) begin
        pwm_c[k] = PWM_MAX;
      end else begin
        pwm_c[k] = pwm[k];
      end
      offs[k] = 16'($signed(pwm_c[k]) - PWM_MID);
      cur[k]  = 16'(offs[k] * PWM_GAIN);
      // slots 1 and 3 spin the other way
      if (k % 2 == 1) begin
        cur[k] = 16'(-cur[k]);
      end
      if (!mask_i[k]) begin
        cur[k] = '0;
      end
      payload[16*k +: 8]     = cur[k][15:8];
      payload[16*k + 8 +: 8] = cur[k][7:0];
    end
  end

  always_comb begin
    drop_o   = 1'b0;
    mask_o   = mask_i;
    result_o = '0;
    if (item_i.req_type == REQ_RX_FRAME) begin
      drop_o = item_i.rx_extended || !found || (item_i.rx_length != FRAME_LEN);
      if (!drop_o) begin
        mask_o = mask_i | NumSlots'(1 << slot);
      end
      result_o.result_kind       = KIND_TELEMETRY;
      result_o.slot_index        = slot;
      result_o.speed_abs         = rpm[15] ? 16'(-rpm) : rpm;
      result_o.current_centiamps = {item_i.rx_payload[39:32], item_i.rx_payload[47:40]};
      result_o.temp_centideg     = 16'(temp_raw * TEMP_SCALE);
      result_o.detected_slots    = mask_o;
    end else begin
      result_o.result_kind    = KIND_COMMAND;
      result_o.detected_slots = mask_i;
      result_o.tx_id          = cfg_i.command_id;
      result_o.tx_length      = FRAME_LEN;
      result_o.tx_payload     = payload;
    end
  end

endmodule

>>> hdl/can_esc_feedback_and_command.sv
// ----------------------------------------------------------------------------
// can_esc_feedback_and_command
// Feedback decoder and current command builder for four CAN motor controllers.
// ----------------------------------------------------------------------------
// item_i carries requests: a received CAN frame (req_type 0) or a command
// request with four PWM widths (req_type 1). result_o carries one telemetry
// record per accepted feedback frame and one command frame per command
// request; rejected frames (extended, unknown id, length not 8) give nothing.
// The feedback and command ids are written through the cfg port; the user must
// write them only while idle, as the block itself does not enforce this. A
// result passes through one input register, the decode logic, then the result
// register. One transaction is taken every cycle while result_o is not stalled;
// the detected mask is updated as an item leaves the input register, so the
// following item already sees it.
// When result_o is stalled the result register holds, the input register
// fills and item_i ready drops; a rejected frame still drains from the input
// register while the output is blocked.
// Reset clears both valid flags and the detected mask and reloads the ids
// with their default values.
// ----------------------------------------------------------------------------
module can_esc_feedback_and_command (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [cef_pkg::CanIdW-1:0] cfg_wdata_i,
  cef_in_if.sink      item_i,
  cef_out_if.source   result_o
);
  import cef_pkg::*;

  cfg_t                cfg_q;
  logic [NumSlots-1:0] mask_q;
  logic [NumSlots-1:0] mask_d;
  logic                s1_valid_q;
  in_item_t            s1_item_q;
  logic                out_valid_q;
  out_item_t           out_item_q;
  out_item_t           res;
  logic                drop;
  logic                out_free;
  logic                s1_fire;
  logic                in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumSlots; k++) begin
        cfg_q.feedback_id[k] <= FEEDBACK_ID_RESET[k];
      end
      cfg_q.command_id <= COMMAND_ID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FEEDBACK_ID_0: cfg_q.feedback_id[0] <= cfg_wdata_i;
        CFG_FEEDBACK_ID_1: cfg_q.feedback_id[1] <= cfg_wdata_i;
        CFG_FEEDBACK_ID_2: cfg_q.feedback_id[2] <= cfg_wdata_i;
        CFG_FEEDBACK_ID_3: cfg_q.feedback_id[3] <= cfg_wdata_i;
        CFG_COMMAND_ID:    cfg_q.command_id     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  cef_item_proc u_proc (
    .item_i   (s1_item_q),
    .cfg_i    (cfg_q),
    .mask_i   (mask_q),
    .drop_o   (drop),
    .mask_o   (mask_d),
    .result_o (res)
  );

  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_fire      = s1_valid_q && (drop || out_free);
  assign item_i.ready = !s1_valid_q || s1_fire;
  assign in_fire      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mask_q      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && !drop) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        mask_q <= mask_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= item_i.data;
    end
    if (s1_fire && !drop) begin
      out_item_q <= res;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_item_q;

endmodule
